// ----- design/cpws_pkg.sv -----
`timescale 1ns / 1ps

package cpws_pkg;

  // Fixed field widths
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned IDX_IN_W = 8;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned KIND_W   = 2;

  localparam logic [WORD_W-1:0] MAGIC_VALUE = 16'hA55A;
  localparam logic [WORD_W-1:0] CRC_SEED    = 16'hFFFF;
  localparam logic [WORD_W-1:0] CRC_POLY    = 16'hA001;
  localparam logic [WORD_W-1:0] BLANK_WORD  = 16'hFFFF;

  // Request kinds; codes 5 to 7 are ignored
  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE = 3'd0,
    ACT_READ  = 3'd1,
    ACT_LOAD  = 3'd2,
    ACT_CHECK = 3'd3,
    ACT_SAVE  = 3'd4
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    RK_READ  = 2'd0,
    RK_CHECK = 2'd1,
    RK_SAVE  = 2'd2
  } result_kind_e;

  // Read address source of the word memory
  typedef enum logic [2:0] {
    RS_CNT,
    RS_CNT_NEXT,
    RS_ITEM,
    RS_MAGIC,
    RS_LAST
  } rd_sel_e;

  typedef enum logic {
    WS_INPUT,
    WS_CRC
  } wr_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_READ_EMIT,
    ST_CRC_RD,
    ST_CRC_A,
    ST_CRC_B,
    ST_CHK_MAGIC,
    ST_CHK_MW,
    ST_CHK_EMIT,
    ST_SAVE_WR,
    ST_SAVE_RD,
    ST_SAVE_EMIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic         item_load;
    logic         rd_en;
    rd_sel_e      rd_sel;
    logic         wr_en;
    wr_sel_e      wr_sel;
    logic         crc_init;
    logic         crc_xor;
    logic         crc_shift;
    logic         cnt_clr;
    logic         cnt_inc;
    logic         magic_chk;
    logic         out_load;
    result_kind_e out_kind;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic cnt_last;
    logic cnt_last_data;
    logic in_wr_ok;
    logic in_ld_ok;
  } sts_t;

  // Eight reflected CRC shifts, half of one word
  function automatic logic [WORD_W-1:0] crc_step8(input logic [WORD_W-1:0] c);
    logic [WORD_W-1:0] r;
    r = c;
    for (int b = 0; b < 8; b++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// ----- design/cpws_ctrl.sv -----
`timescale 1ns / 1ps

module cpws_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic [cpws_pkg::ACTION_W-1:0]     in_action_i,
  output logic                              in_ready_o,
  input  cpws_pkg::sts_t                    sts_i,
  output cpws_pkg::cmd_t                    cmd_o
);

  cpws_pkg::state_e state_q, state_d;
  logic             save_q, save_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpws_pkg::ST_IDLE;
      save_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      save_q  <= save_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    save_d     = save_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.rd_sel   = cpws_pkg::RS_CNT;
    cmd_o.wr_sel   = cpws_pkg::WS_INPUT;
    cmd_o.out_kind = cpws_pkg::RK_READ;

    case (state_q)
      cpws_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_action_i)
            cpws_pkg::ACT_WRITE: begin
              cmd_o.wr_en = sts_i.in_wr_ok;
            end
            cpws_pkg::ACT_LOAD: begin
              cmd_o.wr_en = sts_i.in_ld_ok;
            end
            cpws_pkg::ACT_READ: begin
              cmd_o.item_load = 1'b1;
              state_d         = cpws_pkg::ST_READ;
            end
            cpws_pkg::ACT_CHECK: begin
              cmd_o.cnt_clr  = 1'b1;
              cmd_o.crc_init = 1'b1;
              save_d         = 1'b0;
              state_d        = cpws_pkg::ST_CRC_RD;
            end
            cpws_pkg::ACT_SAVE: begin
              cmd_o.cnt_clr  = 1'b1;
              cmd_o.crc_init = 1'b1;
              save_d         = 1'b1;
              state_d        = cpws_pkg::ST_CRC_RD;
            end
            default: ;
          endcase
        end
      end

      cpws_pkg::ST_READ: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = cpws_pkg::RS_ITEM;
        state_d      = cpws_pkg::ST_READ_EMIT;
      end

      cpws_pkg::ST_READ_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = cpws_pkg::RK_READ;
          state_d        = cpws_pkg::ST_IDLE;
        end
      end

      // CRC walk over the data words: fetch, then two half-word steps
      cpws_pkg::ST_CRC_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = cpws_pkg::RS_CNT;
        state_d      = cpws_pkg::ST_CRC_A;
      end

      cpws_pkg::ST_CRC_A: begin
        cmd_o.crc_xor = 1'b1;
        state_d       = cpws_pkg::ST_CRC_B;
      end

      cpws_pkg::ST_CRC_B: begin
        cmd_o.crc_shift = 1'b1;
        if (sts_i.cnt_last_data) begin
          state_d = save_q ? cpws_pkg::ST_SAVE_WR : cpws_pkg::ST_CHK_MAGIC;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_sel  = cpws_pkg::RS_CNT_NEXT;
          state_d       = cpws_pkg::ST_CRC_A;
        end
      end

      cpws_pkg::ST_CHK_MAGIC: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = cpws_pkg::RS_MAGIC;
        state_d      = cpws_pkg::ST_CHK_MW;
      end

      cpws_pkg::ST_CHK_MW: begin
        cmd_o.magic_chk = 1'b1;
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_sel    = cpws_pkg::RS_LAST;
        state_d         = cpws_pkg::ST_CHK_EMIT;
      end

      cpws_pkg::ST_CHK_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = cpws_pkg::RK_CHECK;
          state_d        = cpws_pkg::ST_IDLE;
        end
      end

      // Store the fresh CRC, then stream out every word
      cpws_pkg::ST_SAVE_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = cpws_pkg::WS_CRC;
        cmd_o.cnt_clr = 1'b1;
        state_d       = cpws_pkg::ST_SAVE_RD;
      end

      cpws_pkg::ST_SAVE_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = cpws_pkg::RS_CNT;
        state_d      = cpws_pkg::ST_SAVE_EMIT;
      end

      cpws_pkg::ST_SAVE_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = cpws_pkg::RK_SAVE;
          if (sts_i.cnt_last) begin
            state_d = cpws_pkg::ST_IDLE;
          end else begin
            cmd_o.cnt_inc = 1'b1;
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_sel  = cpws_pkg::RS_CNT_NEXT;
          end
        end
      end

      default: begin
        state_d = cpws_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/cpws_dpath.sv -----
`timescale 1ns / 1ps

module cpws_dpath #(
  parameter int unsigned STORE_WORDS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [23:0]                       in_data_i,     // word_index, word_value
  input  logic [cpws_pkg::SLOT_W-1:0]       magic_slot_i,
  input  cpws_pkg::cmd_t                    cmd_i,
  output cpws_pkg::sts_t                    sts_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [cpws_pkg::KIND_W-1:0]       out_kind_o,
  output logic [cpws_pkg::SLOT_W-1:0]       out_index_o,
  output logic [cpws_pkg::WORD_W-1:0]       out_word_o,
  output logic                              out_store_valid_o,
  output logic                              out_last_o
);

  localparam int unsigned IW = $clog2(STORE_WORDS);
  localparam logic [8:0]    SW9       = 9'(STORE_WORDS);
  localparam logic [IW-1:0] LAST_ADDR = IW'(STORE_WORDS - 1);
  localparam logic [IW-1:0] LAST_DATA = IW'(STORE_WORDS - 2);

  logic [cpws_pkg::IDX_IN_W-1:0] in_idx;
  logic [cpws_pkg::WORD_W-1:0]   in_val;
  logic [8:0]                    in_idx_w9;

  logic [cpws_pkg::WORD_W-1:0] words_q [STORE_WORDS];
  logic [STORE_WORDS-1:0]      vld_q;
  logic [cpws_pkg::WORD_W-1:0] rd_data_q;
  logic                        rd_vld_q;
  logic [cpws_pkg::WORD_W-1:0] word_rd;

  logic [IW-1:0]               rd_addr, wr_addr, cnt_next;
  logic [cpws_pkg::WORD_W-1:0] wr_data;
  logic [IW-1:0]               cnt_q, cnt_d;
  logic [8:0]                  cnt_w9, item_w9, mag_w9;
  logic [cpws_pkg::IDX_IN_W-1:0] item_idx_q;
  logic                        item_ok_q;
  logic [cpws_pkg::WORD_W-1:0] crc_q, crc_d;
  logic                        magic_ok_q;
  logic                        mag_in_range;

  logic                        out_valid_q, out_valid_d;
  logic [cpws_pkg::KIND_W-1:0] out_kind_q;
  logic [cpws_pkg::SLOT_W-1:0] out_index_q;
  logic [cpws_pkg::WORD_W-1:0] out_word_q;
  logic                        out_sv_q;
  logic                        out_last_q;

  assign in_idx    = in_data_i[7:0];
  assign in_val    = in_data_i[23:8];
  assign in_idx_w9 = {1'b0, in_idx};
  assign cnt_w9    = 9'(cnt_q);
  assign item_w9   = {1'b0, item_idx_q};
  assign mag_w9    = 9'(magic_slot_i);
  assign cnt_next  = cnt_q + IW'(1);
  assign mag_in_range = mag_w9 < SW9;

  // Status to the controller
  assign sts_o.out_free      = !out_valid_q || out_ready_i;
  assign sts_o.cnt_last      = cnt_q == LAST_ADDR;
  assign sts_o.cnt_last_data = cnt_q == LAST_DATA;
  assign sts_o.in_wr_ok      = in_idx_w9 < (SW9 - 9'd1);
  assign sts_o.in_ld_ok      = in_idx_w9 < SW9;

  // Read address select
  always_comb begin
    case (cmd_i.rd_sel)
      cpws_pkg::RS_CNT:      rd_addr = cnt_q;
      cpws_pkg::RS_CNT_NEXT: rd_addr = cnt_next;
      cpws_pkg::RS_ITEM:     rd_addr = item_w9[IW-1:0];
      cpws_pkg::RS_MAGIC:    rd_addr = mag_w9[IW-1:0];
      cpws_pkg::RS_LAST:     rd_addr = LAST_ADDR;
      default:               rd_addr = cnt_q;
    endcase
  end

  // Write port select
  always_comb begin
    case (cmd_i.wr_sel)
      cpws_pkg::WS_CRC: begin
        wr_addr = LAST_ADDR;
        wr_data = crc_q;
      end
      default: begin
        wr_addr = in_idx_w9[IW-1:0];
        wr_data = in_val;
      end
    endcase
  end

  // Word memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      words_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= words_q[rd_addr];
    end
  end

  // Written flags: an unwritten word reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  assign word_rd = rd_vld_q ? rd_data_q : '0;

  // Word counter
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // CRC register, half a word per cycle
  always_comb begin
    crc_d = crc_q;
    if (cmd_i.crc_init) begin
      crc_d = cpws_pkg::CRC_SEED;
    end else if (cmd_i.crc_xor) begin
      crc_d = cpws_pkg::crc_step8(crc_q ^ word_rd);
    end else if (cmd_i.crc_shift) begin
      crc_d = cpws_pkg::crc_step8(crc_q);
    end
  end

  // Request capture, CRC and magic verdict
  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    if (cmd_i.item_load) begin
      item_idx_q <= in_idx;
      item_ok_q  <= sts_o.in_ld_ok;
    end
    if (cmd_i.magic_chk) begin
      magic_ok_q <= mag_in_range && (word_rd == cpws_pkg::MAGIC_VALUE);
    end
  end

  // Output register
  assign out_valid_d = cmd_i.out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_kind_q <= cmd_i.out_kind;
      case (cmd_i.out_kind)
        cpws_pkg::RK_CHECK: begin
          out_index_q <= '0;
          out_word_q  <= '0;
          out_sv_q    <= magic_ok_q && (word_rd == crc_q);
          out_last_q  <= 1'b1;
        end
        cpws_pkg::RK_SAVE: begin
          out_index_q <= cnt_w9[cpws_pkg::SLOT_W-1:0];
          out_word_q  <= word_rd;
          out_sv_q    <= 1'b0;
          out_last_q  <= sts_o.cnt_last;
        end
        default: begin
          out_index_q <= '0;
          out_word_q  <= item_ok_q ? word_rd : cpws_pkg::BLANK_WORD;
          out_sv_q    <= 1'b0;
          out_last_q  <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_kind_o        = out_kind_q;
  assign out_index_o       = out_index_q;
  assign out_word_o        = out_word_q;
  assign out_store_valid_o = out_sv_q;
  assign out_last_o        = out_last_q;

`ifndef SYNTHESIS
  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while held");

  // The word counter never wraps
  a_cnt_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> (cnt_q != LAST_ADDR))
    else $error("word counter wrapped");

  // The CRC slot is written only at the end of the data walk
  a_crc_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_en && cmd_i.wr_sel == cpws_pkg::WS_CRC) |-> (cnt_q == LAST_DATA))
    else $error("CRC stored before the data walk completed");

  // A saved word leaves only after a read of the same slot
  a_save_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && cmd_i.out_kind == cpws_pkg::RK_SAVE) |=>
      out_index_q == $past(cnt_w9[cpws_pkg::SLOT_W-1:0]))
    else $error("saved word index mismatch");
`endif

endmodule

// ----- design/crc_protected_word_store.sv -----
`timescale 1ns / 1ps

// Shadow store of STORE_WORDS 16-bit words; the top word holds a CRC-16/MODBUS
// (seed 0xFFFF, reflected polynomial 0xA001, word-wise) over all words below it,
// and the word at magic_slot must hold 0xA55A. Requests come in on the slave
// stream, with the action in tuser. Write and load give no result; a read
// gives one word (0xFFFF past the end). Check and save walk the data words
// through a single-read-port memory and a CRC unit that does eight bit-shifts
// a cycle, taking each word in halves: a check gives one verdict; a save
// computes and stores the CRC, then fetches word 0 and streams all
// STORE_WORDS words out at one per cycle while the sink is ready, tlast on
// the final one. A new request is taken once the previous one has been
// handed to the result register. The store reads as all zero after reset;
// no clearing pass is needed. magic_slot is set through the APB port at
// address 0.
module crc_protected_word_store #(
  parameter int unsigned STORE_WORDS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [7:0] word_index, [23:8] word_value
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] action
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [5:0] out_index, [21:6] out_word,
                                        // [22] store_valid, [23] zero
  output logic [1:0]  m_axis_tuser_o,   // [1:0] result_kind
  output logic        m_axis_tlast_o,   // last_of_run
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_MAGIC_SLOT = 1'b0;

  logic [cpws_pkg::SLOT_W-1:0] magic_slot_q;
  cpws_pkg::cmd_t              cmd;
  cpws_pkg::sts_t              sts;
  logic [cpws_pkg::SLOT_W-1:0] out_index;
  logic [cpws_pkg::WORD_W-1:0] out_word;
  logic                        out_sv;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_slot_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAGIC_SLOT) begin
      magic_slot_q <= pwdata[cpws_pkg::SLOT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_MAGIC_SLOT) ? {26'd0, magic_slot_q} : 32'd0;

  cpws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_action_i (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cpws_dpath #(
    .STORE_WORDS (STORE_WORDS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_data_i         (s_axis_tdata_i),
    .magic_slot_i      (magic_slot_q),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_ready_i       (m_axis_tready_i),
    .out_valid_o       (m_axis_tvalid_o),
    .out_kind_o        (m_axis_tuser_o),
    .out_index_o       (out_index),
    .out_word_o        (out_word),
    .out_store_valid_o (out_sv),
    .out_last_o        (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, out_sv, out_word, out_index};

endmodule
